FILE: design/cba_pkg.sv
package cba_pkg;

	localparam int WORD_W  = 64;
	localparam int BIT_W   = $clog2(WORD_W);
	localparam int CNT_W   = 13;
	localparam int START_W = 12;

	localparam logic [CNT_W-1:0] COUNT_MAX    = 13'h1FFF;
	localparam logic [CNT_W-1:0] ACTIVE_RESET = 13'd4096;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_A_RD,
		ST_A_SCAN,
		ST_A_FIN,
		ST_C_RD,
		ST_C_WR,
		ST_F_RD,
		ST_F_MOD,
		ST_F_ACC,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] pos;
	} ffs_t;

endpackage

FILE: design/cba_ffs.sv
module cba_ffs (
	input  logic [cba_pkg::WORD_W-1:0] vec,
	output cba_pkg::ffs_t              res
);

	// lowest set bit, binary search over halves
	always_comb begin
		logic [cba_pkg::WORD_W-1:0] v;
		logic [cba_pkg::WORD_W-1:0] low;
		v = vec;
		res.found = |vec;
		res.pos = '0;
		for (int l = cba_pkg::BIT_W - 1; l >= 0; l--) begin
			low = {cba_pkg::WORD_W{1'b1}} >> (cba_pkg::WORD_W - (1 << l));
			if ((v & low) == '0) begin
				res.pos[l] = 1'b1;
				v = v >> (1 << l);
			end
		end
	end

endmodule

FILE: design/contiguous_block_allocator.sv
// Steps: free reads, sets and counts each map word in the range; alloc scans map words
// for runs, then clears the chosen run word by word. Zero-length alloc or empty free range
// goes straight to the response.
// Throughput: one item at a time; the single map port and the find-first unit set it.
// Reset: async, active low; the map then takes a clearing pass during which no item
// is accepted. All blocks used, free count zero.
module contiguous_block_allocator #(
	parameter int NUM_BLOCKS = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cba_pkg::CNT_W-1:0]     cfg_wdata,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic                          req_type,
	input  logic [cba_pkg::CNT_W-1:0]     req_count,
	input  logic [cba_pkg::START_W-1:0]   free_start,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [cba_pkg::START_W-1:0]   grant_start,
	output logic [cba_pkg::CNT_W-1:0]     grant_count,
	output logic                          no_space,
	output logic [cba_pkg::CNT_W-1:0]     free_total
);

	localparam int W      = cba_pkg::WORD_W;
	localparam int BW     = cba_pkg::BIT_W;
	localparam int CW     = cba_pkg::CNT_W;
	localparam int NWORDS = (NUM_BLOCKS + W - 1) / W;
	localparam int WA_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int PW     = ($clog2(NUM_BLOCKS + 1) > CW + 1) ? $clog2(NUM_BLOCKS + 1) : CW + 1;
	localparam int NB     = W / 8;
	localparam int BC_W   = $clog2(8 + 1);
	localparam int SUM_W  = $clog2(W + 1);

	cba_pkg::state_t state_q, state_d;

	logic [CW-1:0]    active_q;
	logic [CW-1:0]    fc_q;
	logic             rsp_valid_q;
	logic [WA_W-1:0]  w_q;
	logic             in_run_q;

	logic             type_q;
	logic [CW-1:0]    count_q;
	logic [PW-1:0]    limit_q;
	logic [WA_W-1:0]  last_w_q;
	logic [BW-1:0]    last_bit_q;
	logic [BW-1:0]    off_q;
	logic [PW-1:0]    run_start_q;
	logic [PW-1:0]    best_start_q;
	logic [CW-1:0]    best_len_q;
	logic [PW-1:0]    lo_q;
	logic [PW-1:0]    hi_q;
	logic [BC_W-1:0]  byte_cnt_q [NB];
	logic [W-1:0]     rdata_q;
	logic [W-1:0]     mem_q [NWORDS];

	logic [cba_pkg::START_W-1:0] grant_start_q;
	logic [CW-1:0]               grant_count_q;
	logic                        no_space_q;
	logic [CW-1:0]               free_total_q;

	logic             accept;
	logic             load_rsp;
	logic             mem_re;
	logic             mem_we;
	logic [W-1:0]     mem_wdata;

	logic [PW-1:0]    limit_c;
	logic [PW-1:0]    lm1_c;
	logic [PW-1:0]    fsum_c;
	logic [PW-1:0]    fhi_c;
	logic [PW-1:0]    flo_c;

	logic [W-1:0]     tgt;
	cba_pkg::ffs_t    ffs;
	logic             is_last;
	logic [PW-1:0]    pos_g;
	logic [PW-1:0]    run_end;
	logic [PW-1:0]    run_len;
	logic [CW-1:0]    len_cap;
	logic             better;
	logic [PW-1:0]    nb_start;
	logic [CW-1:0]    nb_len;
	logic             scan_finish;
	logic             adv_word;

	logic [W-1:0]     rng_mask;
	logic [PW-1:0]    next_base;
	logic             range_done;

	logic [SUM_W-1:0] add_sum;
	logic [CW:0]      fc_sum;
	logic [CW-1:0]    fc_inc;
	logic [CW-1:0]    fc_dec;

	// request decode
	always_comb begin
		limit_c = (PW'(active_q) > PW'(NUM_BLOCKS)) ? PW'(NUM_BLOCKS) : PW'(active_q);
		lm1_c   = limit_c - PW'(1);
		flo_c   = PW'(free_start);
		fsum_c  = PW'(free_start) + PW'(req_count);
		fhi_c   = (fsum_c > limit_c) ? limit_c : fsum_c;
	end

	// run scan on the current word
	always_comb begin
		logic beyond;
		for (int i = 0; i < W; i++) begin
			beyond = (w_q == last_w_q) && (BW'(i) > last_bit_q);
			tgt[i] = (BW'(i) >= off_q) &&
				(in_run_q ? (!rdata_q[i] || beyond) : (rdata_q[i] && !beyond));
		end
	end

	cba_ffs u_ffs (
		.vec (tgt),
		.res (ffs)
	);

	always_comb begin
		is_last     = (w_q == last_w_q);
		pos_g       = PW'({w_q, ffs.pos});
		run_end     = ffs.found ? pos_g : limit_q;
		run_len     = run_end - run_start_q;
		len_cap     = (run_len > PW'(count_q)) ? count_q : CW'(run_len);
		better      = len_cap > best_len_q;
		nb_start    = better ? run_start_q : best_start_q;
		nb_len      = better ? len_cap : best_len_q;
		adv_word    = !ffs.found && !is_last;
		if (in_run_q) begin
			scan_finish = ffs.found ? (nb_len >= count_q) : is_last;
		end else begin
			scan_finish = !ffs.found && is_last;
		end
	end

	// range mask for the current word
	always_comb begin
		logic [PW-1:0] g;
		for (int i = 0; i < W; i++) begin
			g = PW'({w_q, BW'(i)});
			rng_mask[i] = (g >= lo_q) && (g < hi_q);
		end
		next_base  = PW'({w_q, {BW{1'b0}}}) + PW'(W);
		range_done = next_base >= hi_q;
	end

	// free count update
	always_comb begin
		add_sum = '0;
		for (int b = 0; b < NB; b++) begin
			add_sum = add_sum + SUM_W'(byte_cnt_q[b]);
		end
		fc_sum = {1'b0, fc_q} + (CW + 1)'(add_sum);
		fc_inc = (fc_sum > {1'b0, cba_pkg::COUNT_MAX}) ? cba_pkg::COUNT_MAX : CW'(fc_sum);
		fc_dec = (fc_q >= best_len_q) ? fc_q - best_len_q : '0;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cba_pkg::ST_CLEAR: begin
				if (w_q == WA_W'(NWORDS - 1)) state_d = cba_pkg::ST_IDLE;
			end
			cba_pkg::ST_IDLE: begin
				if (req_valid) begin
					if (req_type == cba_pkg::REQ_ALLOC) begin
						state_d = (req_count == '0 || limit_c == '0) ?
							cba_pkg::ST_RESP : cba_pkg::ST_A_RD;
					end else begin
						state_d = (flo_c >= fhi_c) ? cba_pkg::ST_RESP : cba_pkg::ST_F_RD;
					end
				end
			end
			cba_pkg::ST_A_RD:   state_d = cba_pkg::ST_A_SCAN;
			cba_pkg::ST_A_SCAN: begin
				if (scan_finish) state_d = cba_pkg::ST_A_FIN;
				else if (adv_word) state_d = cba_pkg::ST_A_RD;
			end
			cba_pkg::ST_A_FIN: begin
				state_d = (best_len_q == '0) ? cba_pkg::ST_RESP : cba_pkg::ST_C_RD;
			end
			cba_pkg::ST_C_RD:   state_d = cba_pkg::ST_C_WR;
			cba_pkg::ST_C_WR:   state_d = range_done ? cba_pkg::ST_RESP : cba_pkg::ST_C_RD;
			cba_pkg::ST_F_RD:   state_d = cba_pkg::ST_F_MOD;
			cba_pkg::ST_F_MOD:  state_d = cba_pkg::ST_F_ACC;
			cba_pkg::ST_F_ACC:  state_d = range_done ? cba_pkg::ST_RESP : cba_pkg::ST_F_RD;
			cba_pkg::ST_RESP: begin
				if (!rsp_valid_q || rsp_ready) state_d = cba_pkg::ST_IDLE;
			end
			default: state_d = cba_pkg::ST_IDLE;
		endcase
	end

	// controls
	always_comb begin
		req_ready = 1'b0;
		load_rsp  = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_wdata = '0;
		unique case (state_q)
			cba_pkg::ST_CLEAR: mem_we = 1'b1;
			cba_pkg::ST_IDLE:  req_ready = 1'b1;
			cba_pkg::ST_A_RD,
			cba_pkg::ST_C_RD,
			cba_pkg::ST_F_RD:  mem_re = 1'b1;
			cba_pkg::ST_C_WR: begin
				mem_we    = 1'b1;
				mem_wdata = rdata_q & ~rng_mask;
			end
			cba_pkg::ST_F_MOD: begin
				mem_we    = 1'b1;
				mem_wdata = rdata_q | rng_mask;
			end
			cba_pkg::ST_RESP:  load_rsp = !rsp_valid_q || rsp_ready;
			default: begin
			end
		endcase
	end

	assign accept = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cba_pkg::ST_CLEAR;
			active_q    <= cba_pkg::ACTIVE_RESET;
			fc_q        <= '0;
			rsp_valid_q <= 1'b0;
			w_q         <= '0;
			in_run_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) active_q <= cfg_wdata;
			if (load_rsp) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
			case (state_q)
				cba_pkg::ST_CLEAR: begin
					if (w_q != WA_W'(NWORDS - 1)) w_q <= w_q + 1'b1;
				end
				cba_pkg::ST_IDLE: begin
					if (accept) begin
						in_run_q <= 1'b0;
						if (req_type == cba_pkg::REQ_ALLOC) w_q <= '0;
						else w_q <= WA_W'(flo_c >> BW);
					end
				end
				cba_pkg::ST_A_SCAN: begin
					if (ffs.found) in_run_q <= !in_run_q;
					if (adv_word) w_q <= w_q + 1'b1;
				end
				cba_pkg::ST_A_FIN: w_q <= WA_W'(best_start_q >> BW);
				cba_pkg::ST_C_WR: begin
					if (range_done) fc_q <= fc_dec;
					else w_q <= w_q + 1'b1;
				end
				cba_pkg::ST_F_ACC: begin
					fc_q <= fc_inc;
					if (!range_done) w_q <= w_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			cba_pkg::ST_IDLE: begin
				if (accept) begin
					type_q       <= req_type;
					count_q      <= req_count;
					best_start_q <= '0;
					best_len_q   <= '0;
					off_q        <= '0;
					limit_q      <= limit_c;
					last_w_q     <= WA_W'(lm1_c >> BW);
					last_bit_q   <= lm1_c[BW-1:0];
					lo_q         <= flo_c;
					hi_q         <= fhi_c;
				end
			end
			cba_pkg::ST_A_SCAN: begin
				off_q <= ffs.found ? ffs.pos : '0;
				if (!in_run_q && ffs.found) run_start_q <= pos_g;
				if (in_run_q && (ffs.found || is_last)) begin
					best_start_q <= nb_start;
					best_len_q   <= nb_len;
				end
			end
			cba_pkg::ST_A_FIN: begin
				lo_q <= best_start_q;
				hi_q <= best_start_q + PW'(best_len_q);
			end
			cba_pkg::ST_F_MOD: begin
				for (int b = 0; b < NB; b++) begin
					byte_cnt_q[b] <= BC_W'($countones(rng_mask[b*8 +: 8] & ~rdata_q[b*8 +: 8]));
				end
			end
			default: begin
			end
		endcase
		if (load_rsp) begin
			grant_start_q <= cba_pkg::START_W'(best_start_q);
			grant_count_q <= best_len_q;
			no_space_q    <= (type_q == cba_pkg::REQ_ALLOC) && (count_q != '0) &&
				(best_len_q == '0);
			free_total_q  <= fc_q;
		end
	end

	// free map words
	always_ff @(posedge clk) begin
		if (mem_we) mem_q[w_q] <= mem_wdata;
		if (mem_re) rdata_q <= mem_q[w_q];
	end

	assign rsp_valid   = rsp_valid_q;
	assign grant_start = grant_start_q;
	assign grant_count = grant_count_q;
	assign no_space    = no_space_q;
	assign free_total  = free_total_q;

endmodule

FILE: design/cba_checker.sv
module cba_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [cba_pkg::START_W-1:0]   grant_start,
	input logic [cba_pkg::CNT_W-1:0]     grant_count,
	input logic                          no_space,
	input logic [cba_pkg::CNT_W-1:0]     free_total
);

	// result holds while stalled
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(grant_start) &&
			$stable(grant_count) && $stable(no_space) && $stable(free_total))
		else $error("result changed while stalled");

	// one item at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ready stayed high after an accepted item");

	// a failed alloc grants nothing
	a_no_space_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && no_space |-> grant_count == '0 && grant_start == '0)
		else $error("no_space with a nonzero grant");

	// a new result appears only out of a busy cycle
	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_ready))
		else $error("result raised while idle");

endmodule

bind contiguous_block_allocator cba_checker u_cba_checker (.*);
